/* hw/rtl/boa_pkg.sv */
// Shared types, codes and widths of the block ownership audit core.
package boa_pkg;

  localparam int unsigned BlockW       = 32;
  localparam int unsigned InodeW       = 8;
  localparam int unsigned CfgW         = 13;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned DefMaxBlocks = 4096;

  localparam logic [CfgIdxW-1:0] CfgFirstDataBlock = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTotalBlocks    = 1'b1;

  localparam logic [0:0] OpClaim = 1'b0;

  typedef enum logic [StatusW-1:0] {
    StOk       = 3'd0,
    StRange    = 3'd1,
    StDouble   = 3'd2,
    StLeak     = 3'd3,
    StFreeUsed = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CtlClear,
    CtlIdle,
    CtlEval
  } ctl_state_e;

  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic commit;
  } boa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } boa_sts_t;

endpackage

/* hw/rtl/boa_ctrl.sv */
// Controller state machine: clearing pass, item accept and evaluation.
module boa_ctrl
  import boa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  boa_sts_t sts_i,
  output boa_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtlClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      CtlClear: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = CtlIdle;
        end
      end
      CtlIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = CtlEval;
        end
      end
      CtlEval: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = CtlIdle;
        end
      end
      default: begin
        state_d = CtlClear;
      end
    endcase
  end

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CtlClear) |-> !in_ready_o)
    else $error("input ready during clearing pass");

  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == CtlEval))
    else $error("accepted transaction not evaluated next");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !sts_i.out_busy)
    else $error("commit while result register is held");
`endif

endmodule

/* hw/rtl/boa_dpath.sv */
// Datapath: configuration, owner table memory, checks and result register.
module boa_dpath
  import boa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = DefMaxBlocks
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  boa_cmd_t            cmd_i,
  output boa_sts_t            sts_o,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                op_i,
  input  logic [BlockW-1:0]   block_number_i,
  input  logic [InodeW-1:0]   inode_number_i,
  input  logic                bitmap_in_use_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [InodeW-1:0]   other_inode_o
);

  localparam int unsigned AddrW = $clog2(MAX_BLOCKS);

  logic [CfgW-1:0]   first_q, total_q;
  logic [AddrW-1:0]  clr_cnt_q;
  logic              op_q, in_use_q;
  logic [BlockW-1:0] blk_q;
  logic [InodeW-1:0] inode_q;
  logic [InodeW-1:0] who_q;
  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [InodeW-1:0] other_q, other_d;
  logic              wr_en;
  logic              in_region;

  logic [InodeW-1:0] owner_mem [MAX_BLOCKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      total_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFirstDataBlock: first_q <= cfg_data_i;
        CfgTotalBlocks:    total_q <= cfg_data_i;
        default:           first_q <= first_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= op_i;
      blk_q    <= block_number_i;
      inode_q  <= inode_number_i;
      in_use_q <= bitmap_in_use_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      owner_mem[clr_cnt_q] <= '0;
    end else if (wr_en) begin
      owner_mem[blk_q[AddrW-1:0]] <= inode_q;
    end
    if (cmd_i.capture) begin
      who_q <= owner_mem[block_number_i[AddrW-1:0]];
    end
  end

  assign in_region = (blk_q >= BlockW'(first_q)) && (blk_q < BlockW'(total_q)) &&
                     (blk_q < BlockW'(MAX_BLOCKS));

  always_comb begin
    status_d = StOk;
    other_d  = '0;
    wr_en    = 1'b0;
    if (op_q == OpClaim) begin
      if (blk_q != '0) begin
        if (!in_region) begin
          status_d = StRange;
        end else if (who_q != '0) begin
          status_d = StDouble;
          other_d  = who_q;
        end else begin
          wr_en = cmd_i.commit;
        end
      end
    end else begin
      if (!in_region) begin
        status_d = StRange;
      end else if (in_use_q && (who_q == '0)) begin
        status_d = StLeak;
      end else if (!in_use_q && (who_q != '0)) begin
        status_d = StFreeUsed;
        other_d  = who_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      other_q  <= other_d;
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == AddrW'(MAX_BLOCKS - 1));
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign other_inode_o  = other_q;

`ifndef SYNTH
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_write_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (cmd_i.commit && !cmd_i.clr_wr && in_region && (who_q == '0)))
    else $error("owner write outside a free in-region claim");

  a_other_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (status_d != StDouble) && (status_d != StFreeUsed))
      |=> (other_inode_o == '0))
    else $error("other inode set without an owner report");
`endif

endmodule

/* hw/rtl/block_ownership_audit_core.sv */
// Top level of the block ownership audit core: controller plus datapath.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_ready_o   op, block_number, inode_number, bitmap_in_use
//   out      source     out_valid_o/out_ready_i status, other_inode
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item is accepted with the owner table read, then evaluated and written.
// The owner table read data is registered; no new item is accepted until the result is committed.
// After reset a clearing pass zeroes all MAX_BLOCKS table entries; no input is taken.
// A held result stalls evaluation of the following item; configuration is always taken.
module block_ownership_audit_core
  import boa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = DefMaxBlocks
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [BlockW-1:0]  block_number_i,
  input  logic [InodeW-1:0]  inode_number_i,
  input  logic               bitmap_in_use_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [InodeW-1:0]  other_inode_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  boa_cmd_t cmd;
  boa_sts_t sts;

  assign cfg_ready_o = 1'b1;

  boa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  boa_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .block_number_i  (block_number_i),
    .inode_number_i  (inode_number_i),
    .bitmap_in_use_i (bitmap_in_use_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .other_inode_o   (other_inode_o)
  );

endmodule

/* test/block_ownership_audit_checker.sv */
// Checker that tracks block ownership and compares each audit core result with its prediction.
module block_ownership_audit_checker
  import boa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = DefMaxBlocks
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               op_i,
  input  logic [BlockW-1:0]  block_number_i,
  input  logic [InodeW-1:0]  inode_number_i,
  input  logic               bitmap_in_use_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [InodeW-1:0]  other_inode_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int unsigned        mismatches_o,
  output int unsigned        outstanding_o,
  output int unsigned        verdicts_o,
  output logic [4:0]         status_hit_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e           status;
    logic [InodeW-1:0] owner;
  } verdict_t;

  verdict_t          pending_verdicts[$];
  logic [InodeW-1:0] owner_copy[MAX_BLOCKS];
  logic [CfgW-1:0]   region_lo;
  logic [CfgW-1:0]   region_hi;
  int unsigned       mismatch_total = 0;
  int unsigned       verdict_total  = 0;
  logic [4:0]        seen_status    = '0;

  function automatic logic in_region(logic [BlockW-1:0] blk);
    return (blk >= region_lo) && (blk < region_hi) && (blk < MAX_BLOCKS);
  endfunction

  function automatic verdict_t resolve_item(logic op, logic [BlockW-1:0] blk,
                                            logic [InodeW-1:0] ino, logic in_use);
    verdict_t          v;
    logic [InodeW-1:0] holder;
    v.status = StOk;
    v.owner  = '0;
    if (op == OpClaim) begin
      if (blk != '0) begin
        if (!in_region(blk)) begin
          v.status = StRange;
        end else begin
          holder = owner_copy[blk];
          if (holder != '0) begin
            v.status = StDouble;
            v.owner  = holder;
          end else begin
            owner_copy[blk] = ino;
          end
        end
      end
    end else if (!in_region(blk)) begin
      v.status = StRange;
    end else begin
      holder = owner_copy[blk];
      if (in_use && holder == '0) begin
        v.status = StLeak;
      end else if (!in_use && holder != '0) begin
        v.status = StFreeUsed;
        v.owner  = holder;
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, int unsigned want_v, int unsigned got_v);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want_v, got_v);
    mismatch_total++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    verdict_t want;
    if (!rst_ni) begin
      pending_verdicts.delete();
      for (int i = 0; i < MAX_BLOCKS; i++) owner_copy[i] = '0;
      region_lo = '0;
      region_hi = '0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgFirstDataBlock) begin
          region_lo = cfg_data_i;
        end else if (cfg_index_i == CfgTotalBlocks) begin
          region_hi = cfg_data_i;
        end
      end
      if (out_valid_i && out_ready_i) begin
        verdict_total++;
        if (status_i <= StFreeUsed) seen_status[status_i] = 1'b1;
        if (pending_verdicts.size() == 0) begin
          report_mismatch("status of a result with no pending transaction", 0, status_i);
        end else begin
          want = pending_verdicts.pop_front();
          if (status_i != want.status) report_mismatch("status", want.status, status_i);
          if (other_inode_i != want.owner) begin
            report_mismatch("other_inode", want.owner, other_inode_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_verdicts.push_back(resolve_item(op_i, block_number_i, inode_number_i,
                                                bitmap_in_use_i));
      end
      outstanding_o <= int'(pending_verdicts.size());
    end
    mismatches_o <= mismatch_total;
    verdicts_o   <= verdict_total;
    status_hit_o <= seen_status;
  end

endmodule

/* test/block_ownership_audit_core_tb.sv */
// Testbench top of the block ownership audit core: stimulus, pacing and verdict.
module block_ownership_audit_core_tb
  import boa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [0:0]  OpAudit    = 1'b1;
  localparam int unsigned WatchLimit = 20000;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic               op            = OpClaim;
  logic [BlockW-1:0]  block_number  = '0;
  logic [InodeW-1:0]  inode_number  = '0;
  logic               bitmap_in_use = 1'b0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [StatusW-1:0] status;
  logic [InodeW-1:0]  other_inode;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index     = CfgFirstDataBlock;
  logic [CfgW-1:0]    cfg_data      = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned verdicts;
  logic [4:0]  status_hit;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold      = 0;
  int unsigned stall_cycles = 0;
  int unsigned items_sent   = 0;
  int unsigned regions_set  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  block_ownership_audit_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (op),
    .block_number_i (block_number),
    .inode_number_i (inode_number),
    .bitmap_in_use_i(bitmap_in_use),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .other_inode_o  (other_inode),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  block_ownership_audit_checker i_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .op_i           (op),
    .block_number_i (block_number),
    .inode_number_i (inode_number),
    .bitmap_in_use_i(bitmap_in_use),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .other_inode_i  (other_inode),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .verdicts_o     (verdicts),
    .status_hit_o   (status_hit)
  );

  function automatic int unsigned idle_len(int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [BlockW-1:0] pick_block(int unsigned lo, int unsigned hi);
    int unsigned region_end;
    int unsigned span;
    int unsigned roll;
    region_end = (hi < DefMaxBlocks) ? hi : DefMaxBlocks;
    span = (lo < region_end) ? region_end - lo : 0;
    roll = $urandom_range(0, 99);
    if (span != 0 && roll < 45) return lo + $urandom_range(0, ((span < 48) ? span : 48) - 1);
    if (span != 0 && roll < 70) return lo + $urandom_range(0, span - 1);
    if (roll < 82) begin
      case ($urandom_range(0, 7))
        0: return lo - 1;
        1: return lo;
        2: return region_end - 1;
        3: return region_end;
        4: return 0;
        5: return DefMaxBlocks - 1;
        6: return DefMaxBlocks;
        default: return hi;
      endcase
    end
    if (roll < 92) return $urandom;
    return $urandom_range(0, 4200);
  endfunction

  // Hold ready low for random stretches; none while the stall rate is zero.
  always @(posedge clk_i) begin : rx_pace
    int unsigned hold_len;
    if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else begin
      hold_len = idle_len(rx_stall_pct);
      out_ready <= (hold_len == 0);
      rx_hold   <= (hold_len == 0) ? 0 : hold_len - 1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WatchLimit) begin
      $display("watchdog: no transaction for %0d cycles", WatchLimit);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(logic item_op, logic [BlockW-1:0] blk, logic [InodeW-1:0] ino,
                           logic in_use);
    int unsigned gap;
    gap = idle_len(tx_idle_pct);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    op            <= item_op;
    block_number  <= blk;
    inode_number  <= ino;
    bitmap_in_use <= in_use;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic end_burst();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic set_region(logic [CfgW-1:0] lo, logic [CfgW-1:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= CfgFirstDataBlock;
    cfg_data  <= lo;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CfgTotalBlocks;
    cfg_data  <= hi;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    regions_set++;
  endtask

  task automatic run_phase(int unsigned lo, int unsigned hi, int unsigned count,
                           int unsigned tx_pct, int unsigned rx_pct, bit mid_drain);
    logic [InodeW-1:0] ino;
    end_burst();
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    set_region(CfgW'(lo), CfgW'(hi));
    for (int unsigned i = 0; i < count; i++) begin
      if (mid_drain && i == count / 2) end_burst();
      ino = ($urandom_range(0, 19) == 0) ? '0 : InodeW'($urandom);
      send_item(logic'($urandom_range(0, 1)), pick_block(lo, hi), ino,
                logic'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned lo;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct  = 20;
    rx_stall_pct = 20;

    set_region('0, CfgW'(DefMaxBlocks));
    send_item(OpClaim, 0, 5, 1'b0);
    send_item(OpAudit, 0, 0, 1'b1);
    send_item(OpAudit, 0, 0, 1'b0);
    send_item(OpClaim, DefMaxBlocks - 1, 8'hFF, 1'b0);
    send_item(OpClaim, DefMaxBlocks - 1, 7, 1'b1);
    send_item(OpAudit, DefMaxBlocks - 1, 0, 1'b0);
    send_item(OpAudit, DefMaxBlocks - 1, 0, 1'b1);
    send_item(OpClaim, DefMaxBlocks, 3, 1'b0);
    send_item(OpClaim, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_item(OpAudit, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_item(OpAudit, DefMaxBlocks, 0, 1'b1);
    send_item(OpClaim, 10, 0, 1'b0);
    send_item(OpAudit, 10, 0, 1'b1);
    send_item(OpClaim, 10, 3, 1'b0);
    send_item(OpAudit, 10, 0, 1'b1);
    send_item(OpAudit, 10, 0, 1'b0);
    send_item(OpAudit, 2, 0, 1'b0);
    end_burst();
    set_region(CfgW'(100), CfgW'(200));
    send_item(OpClaim, 99, 9, 1'b0);
    send_item(OpClaim, 100, 9, 1'b0);
    send_item(OpClaim, 199, 8'h80, 1'b0);
    send_item(OpClaim, 200, 1, 1'b0);
    send_item(OpAudit, 99, 0, 1'b1);
    send_item(OpAudit, 0, 0, 1'b1);
    send_item(OpClaim, 0, 4, 1'b0);
    end_burst();
    set_region(CfgW'(300), CfgW'(200));
    send_item(OpClaim, 250, 6, 1'b0);
    send_item(OpAudit, 150, 0, 1'b0);

    run_phase(1, DefMaxBlocks, 380, 10, 10, 1'b0);
    run_phase(0, 8191, 330, 0, 0, 1'b0);
    run_phase(2048, 2100, 300, 40, 40, 1'b0);
    run_phase(4000, DefMaxBlocks, 250, 15, 30, 1'b0);
    run_phase(DefMaxBlocks, DefMaxBlocks, 50, 10, 10, 1'b0);
    run_phase(0, 0, 50, 10, 10, 1'b0);
    lo = $urandom_range(0, DefMaxBlocks);
    run_phase(lo, $urandom_range(0, DefMaxBlocks), 200, 20, 20, 1'b0);
    lo = $urandom_range(0, 3000);
    run_phase(lo, lo + $urandom_range(1, 1096), 200, 25, 15, 1'b0);
    run_phase(5, 37, 200, 30, 5, 1'b1);
    end_burst();
    rx_stall_pct = 0;
    repeat (8) @(posedge clk_i);

    $display("covered %0d input transactions over %0d region settings, %0d results checked",
             items_sent, regions_set, verdicts);
    $display("statuses observed, free-used down to ok: %b", status_hit);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
